// ===== design/rld_pkg.sv =====
// Shared types, constants and datapath command codes for the deconvolution unit.
// No dependencies; imported by every other file of the block.
`default_nettype none

package rld_pkg;

  // Default sizes of the stores.
  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int MAX_KERNEL_DEF = 7;

  // Fixed formats: Q8.8 pixels, Q0.16 kernel, Q8.16 correction.
  localparam int PIX_W  = 16;
  localparam int CORR_W = 24;
  localparam int NUM_W  = 32;

  localparam logic [PIX_W-1:0]  PIX_MAX  = 16'hFF00;
  localparam logic [CORR_W-1:0] CORR_MAX = 24'hFFFFFF;

  // Configuration register reset values.
  localparam logic [6:0] IMAGE_ROWS_RST = 7'd64;
  localparam logic [6:0] IMAGE_COLS_RST = 7'd64;
  localparam logic [2:0] KERNEL_ROWS_RST = 3'd3;
  localparam logic [2:0] KERNEL_COLS_RST = 3'd3;
  localparam logic [7:0] ITERATIONS_RST = 8'd10;

  typedef enum logic [2:0] {
    CFG_IMAGE_ROWS  = 3'd0,
    CFG_IMAGE_COLS  = 3'd1,
    CFG_KERNEL_ROWS = 3'd2,
    CFG_KERNEL_COLS = 3'd3,
    CFG_ITERATIONS  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FUNC_LOAD_KERNEL = 2'd0,
    FUNC_LOAD_PIXEL  = 2'd1,
    FUNC_RUN         = 2'd2,
    FUNC_READ        = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LD_KERN,
    DP_LD_PIX,
    DP_OUT_PIX,
    DP_OUT_ZERO,
    DP_OUT_RUN,
    DP_RB_CLR,
    DP_RB_MAC,
    DP_RB_STORE,
    DP_CO_CLR,
    DP_CO_MUL,
    DP_DIV_START,
    DP_CO_ACC,
    DP_EST_MUL,
    DP_NEXT_STORE,
    DP_CP_STORE
  } dp_op_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [5:0]       row;
    logic [5:0]       col;
    logic [PIX_W-1:0] observed_pixel;
    logic [PIX_W-1:0] estimate_pixel;
    logic [PIX_W-1:0] coefficient;
  } rld_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             run_done;
  } rld_out_t;

  typedef struct packed {
    logic [6:0] image_rows;
    logic [6:0] image_cols;
    logic [2:0] kernel_rows;
    logic [2:0] kernel_cols;
    logic [7:0] iterations;
  } rld_cfg_t;

  typedef struct packed {
    dp_op_e op;
  } rld_cmd_t;

  typedef struct packed {
    logic div_done;
    logic den_zero;
  } rld_status_t;

endpackage

`default_nettype wire

// ===== design/rld_div.sv =====
// Restoring divider for one correction term: floor((num << 16) / den), saturated to Q8.16.
// Depends on rld_pkg.
`default_nettype none

module rld_div #(
  parameter int DEN_W = 38
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rld_pkg::NUM_W-1:0]   num_i,
  input  wire logic [DEN_W-1:0]            den_i,
  output logic                             done_o,
  output logic [rld_pkg::CORR_W-1:0]       quot_o
);
  import rld_pkg::*;

  localparam int CNT_W = $clog2(CORR_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CORR_W-1:0] sh_q;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic             ovf;

  // Quotient reaches 2^24 exactly when num >= den * 2^8.
  assign ovf   = (DEN_W + 8)'(num_i) >= {den_i, 8'b0};
  assign trial = {rem_q, sh_q[CORR_W-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign rem_d = ge ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
      if (ovf) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(CORR_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Payload: remainder and shift register, no reset.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (ovf) begin
        sh_q <= CORR_MAX;
      end else begin
        rem_q <= DEN_W'(num_i[NUM_W-1:8]);
        sh_q  <= {num_i[7:0], 16'b0};
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[CORR_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

`default_nettype wire

// ===== design/rld_datapath.sv =====
// Datapath: image, kernel, reblur and next-estimate memories, MAC, divider and clamps.
// Depends on rld_pkg and rld_div; driven by rld_ctrl through rld_cmd_t.
`default_nettype none

module rld_datapath #(
  parameter int MAX_ROWS   = rld_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = rld_pkg::MAX_COLS_DEF,
  parameter int MAX_KERNEL = rld_pkg::MAX_KERNEL_DEF,
  parameter int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1,
  parameter int KAW = (MAX_KERNEL * MAX_KERNEL > 1) ? $clog2(MAX_KERNEL * MAX_KERNEL) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rld_pkg::rld_cmd_t    cmd_i,
  input  wire logic [AW-1:0]        pix_addr_i,
  input  wire logic [KAW-1:0]       kern_addr_i,
  input  wire rld_pkg::rld_in_t     in_data_i,
  output rld_pkg::rld_status_t      status_o,
  output rld_pkg::rld_out_t         out_data_o
);
  import rld_pkg::*;

  localparam int PIX_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int KERN_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int RBW = NUM_W + ((KERN_DEPTH > 1) ? $clog2(KERN_DEPTH) : 0);

  logic [PIX_W-1:0] obs_mem  [PIX_DEPTH];
  logic [PIX_W-1:0] est_mem  [PIX_DEPTH];
  logic [PIX_W-1:0] next_mem [PIX_DEPTH];
  logic [RBW-1:0]   rb_mem   [PIX_DEPTH];
  logic [PIX_W-1:0] kern_mem [KERN_DEPTH];

  logic [PIX_W-1:0]  obs_rd_q, est_rd_q, next_rd_q, kern_rd_q;
  logic [RBW-1:0]    rb_rd_q;
  logic [RBW-1:0]    rb_acc_q;
  logic [NUM_W-1:0]  num_q;
  logic [RBW-1:0]    den_q;
  logic [CORR_W-1:0] corr_q;
  logic [PIX_W+CORR_W-1:0] prod_q;
  logic [PIX_W-1:0]  out_pix_q;
  logic              out_done_q;

  logic [NUM_W-1:0]  mac_prod;
  logic [CORR_W:0]   corr_sum;
  logic [CORR_W-1:0] corr_next;
  logic [CORR_W-1:0] new_full;
  logic [PIX_W-1:0]  new_pix;
  logic [PIX_W-1:0]  est_wdata;
  logic              est_we;
  logic              div_done;
  logic [CORR_W-1:0] quot;

  assign mac_prod  = est_rd_q * kern_rd_q;
  assign corr_sum  = {1'b0, corr_q} + {1'b0, quot};
  assign corr_next = (corr_sum > {1'b0, CORR_MAX}) ? CORR_MAX : corr_sum[CORR_W-1:0];
  assign new_full  = prod_q[PIX_W+CORR_W-1:16];
  assign new_pix   = (new_full > CORR_W'(PIX_MAX)) ? PIX_MAX : new_full[PIX_W-1:0];

  assign est_we    = (cmd_i.op == DP_LD_PIX) || (cmd_i.op == DP_CP_STORE);
  assign est_wdata = (cmd_i.op == DP_LD_PIX) ? in_data_i.estimate_pixel : next_rd_q;

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LD_PIX) obs_mem[pix_addr_i] <= in_data_i.observed_pixel;
    obs_rd_q <= obs_mem[pix_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (est_we) est_mem[pix_addr_i] <= est_wdata;
    est_rd_q <= est_mem[pix_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_NEXT_STORE) next_mem[pix_addr_i] <= new_pix;
    next_rd_q <= next_mem[pix_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_RB_STORE) rb_mem[pix_addr_i] <= rb_acc_q;
    rb_rd_q <= rb_mem[pix_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LD_KERN) kern_mem[kern_addr_i] <= in_data_i.coefficient;
    kern_rd_q <= kern_mem[kern_addr_i];
  end

  // Arithmetic registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_RB_CLR:  rb_acc_q <= '0;
      DP_RB_MAC:  rb_acc_q <= rb_acc_q + RBW'(mac_prod);
      DP_CO_CLR:  corr_q   <= '0;
      DP_CO_MUL: begin
        num_q <= obs_rd_q * kern_rd_q;
        den_q <= rb_rd_q;
      end
      DP_CO_ACC:  corr_q   <= corr_next;
      DP_EST_MUL: prod_q   <= est_rd_q * corr_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_pix_q  <= '0;
      out_done_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        DP_OUT_PIX: begin
          out_pix_q  <= est_rd_q;
          out_done_q <= 1'b0;
        end
        DP_OUT_ZERO: begin
          out_pix_q  <= '0;
          out_done_q <= 1'b0;
        end
        DP_OUT_RUN: begin
          out_pix_q  <= '0;
          out_done_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  rld_div #(
    .DEN_W (RBW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == DP_DIV_START),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign status_o.div_done = div_done;
  assign status_o.den_zero = (den_q == '0);

  assign out_data_o.pixel_value = out_pix_q;
  assign out_data_o.run_done    = out_done_q;

endmodule

`default_nettype wire

// ===== design/rld_ctrl.sv =====
// Controller: handshake, loop counters over pixels and kernel window, and datapath commands.
// Depends on rld_pkg; drives rld_datapath through rld_cmd_t and addresses.
`default_nettype none

module rld_ctrl #(
  parameter int MAX_ROWS   = rld_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = rld_pkg::MAX_COLS_DEF,
  parameter int MAX_KERNEL = rld_pkg::MAX_KERNEL_DEF,
  parameter int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1,
  parameter int KAW = (MAX_KERNEL * MAX_KERNEL > 1) ? $clog2(MAX_KERNEL * MAX_KERNEL) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire rld_pkg::rld_in_t     in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire rld_pkg::rld_cfg_t    cfg_i,
  input  wire rld_pkg::rld_status_t status_i,
  output rld_pkg::rld_cmd_t         cmd_o,
  output logic [AW-1:0]             pix_addr_o,
  output logic [KAW-1:0]            kern_addr_o
);
  import rld_pkg::*;

  localparam logic [2:0] HMAX = 3'((MAX_KERNEL - 1) / 2);

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_RUN_INIT,
    S_RB_CLR, S_RB_ADDR, S_RB_MAC, S_RB_STORE,
    S_CO_CLR, S_CO_ADDR, S_CO_MUL, S_CO_DIV, S_CO_WAIT,
    S_EST_ADDR, S_EST_MUL, S_NEXT_STORE,
    S_CP_ADDR, S_CP_STORE, S_ITER_END, S_DONE
  } state_e;

  state_e     state_q;
  logic [6:0] r_q, c_q, nr_q, nc_q;
  logic [3:0] d1_q, d2_q;
  logic [2:0] hr_q, hc_q;
  logic [7:0] it_q;
  logic       out_valid_q;
  logic       rd_in_q;

  logic signed [9:0] win_r, win_c;
  logic win_ok, win_last, pix_last, accept;
  logic in_img, kern_ok;
  logic [2:0] hr_new, hc_new;

  function automatic logic [AW-1:0] paddr_of(logic [9:0] rr, logic [9:0] cc);
    logic [31:0] full;
    full = 32'(rr) * 32'(MAX_COLS) + 32'(cc);
    return full[AW-1:0];
  endfunction

  function automatic logic [KAW-1:0] kaddr_of(logic [5:0] rr, logic [5:0] cc);
    logic [31:0] full;
    full = 32'(rr) * 32'(MAX_KERNEL) + 32'(cc);
    return full[KAW-1:0];
  endfunction

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign in_img  = (32'(in_data_i.row) < 32'(MAX_ROWS)) && (32'(in_data_i.col) < 32'(MAX_COLS));
  assign kern_ok = (32'(in_data_i.row) < 32'(MAX_KERNEL)) &&
                   (32'(in_data_i.col) < 32'(MAX_KERNEL));

  assign hr_new = ({1'b0, cfg_i.kernel_rows[2:1]} > HMAX) ? HMAX : {1'b0, cfg_i.kernel_rows[2:1]};
  assign hc_new = ({1'b0, cfg_i.kernel_cols[2:1]} > HMAX) ? HMAX : {1'b0, cfg_i.kernel_cols[2:1]};

  // Window position relative to the current pixel.
  assign win_r = $signed({3'b0, r_q}) - $signed({7'b0, hr_q}) + $signed({6'b0, d1_q});
  assign win_c = $signed({3'b0, c_q}) - $signed({7'b0, hc_q}) + $signed({6'b0, d2_q});
  assign win_ok = !win_r[9] && !win_c[9] &&
                  (win_r < $signed({3'b0, nr_q})) && (win_c < $signed({3'b0, nc_q}));
  assign win_last = (d1_q == {hr_q, 1'b0}) && (d2_q == {hc_q, 1'b0});
  assign pix_last = (r_q == nr_q - 7'd1) && (c_q == nc_q - 7'd1);

  always_comb begin
    cmd_o.op    = DP_NOP;
    pix_addr_o  = paddr_of({3'b0, r_q}, {3'b0, c_q});
    kern_addr_o = kaddr_of({2'b0, d1_q}, {2'b0, d2_q});
    unique case (state_q)
      S_IDLE: begin
        pix_addr_o  = in_img ? paddr_of({4'b0, in_data_i.row}, {4'b0, in_data_i.col}) : '0;
        kern_addr_o = kern_ok ? kaddr_of(in_data_i.row, in_data_i.col) : '0;
        if (accept && in_data_i.func == FUNC_LOAD_KERNEL && kern_ok) cmd_o.op = DP_LD_KERN;
        if (accept && in_data_i.func == FUNC_LOAD_PIXEL && in_img)   cmd_o.op = DP_LD_PIX;
      end
      S_READ:       cmd_o.op = rd_in_q ? DP_OUT_PIX : DP_OUT_ZERO;
      S_RB_CLR:     cmd_o.op = DP_RB_CLR;
      S_RB_ADDR:    pix_addr_o = paddr_of($unsigned(win_r), $unsigned(win_c));
      S_RB_MAC:     cmd_o.op = DP_RB_MAC;
      S_RB_STORE:   cmd_o.op = DP_RB_STORE;
      S_CO_CLR:     cmd_o.op = DP_CO_CLR;
      S_CO_ADDR:    pix_addr_o = paddr_of($unsigned(win_r), $unsigned(win_c));
      S_CO_MUL:     cmd_o.op = DP_CO_MUL;
      S_CO_DIV:     cmd_o.op = status_i.den_zero ? DP_NOP : DP_DIV_START;
      S_CO_WAIT:    cmd_o.op = status_i.div_done ? DP_CO_ACC : DP_NOP;
      S_EST_MUL:    cmd_o.op = DP_EST_MUL;
      S_NEXT_STORE: cmd_o.op = DP_NEXT_STORE;
      S_CP_STORE:   cmd_o.op = DP_CP_STORE;
      S_DONE:       cmd_o.op = DP_OUT_RUN;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rd_in_q     <= 1'b0;
      r_q  <= '0;
      c_q  <= '0;
      d1_q <= '0;
      d2_q <= '0;
      nr_q <= '0;
      nc_q <= '0;
      hr_q <= '0;
      hc_q <= '0;
      it_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (accept && in_data_i.func == FUNC_READ) begin
            rd_in_q <= in_img;
            state_q <= S_READ;
          end
          if (accept && in_data_i.func == FUNC_RUN) begin
            nr_q <= (32'(cfg_i.image_rows) > 32'(MAX_ROWS)) ? 7'(MAX_ROWS) : cfg_i.image_rows;
            nc_q <= (32'(cfg_i.image_cols) > 32'(MAX_COLS)) ? 7'(MAX_COLS) : cfg_i.image_cols;
            hr_q <= hr_new;
            hc_q <= hc_new;
            it_q <= '0;
            state_q <= S_RUN_INIT;
          end
        end
        S_READ: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        S_RUN_INIT: begin
          r_q <= '0;
          c_q <= '0;
          if (cfg_i.iterations == 8'd0 || nr_q == 7'd0 || nc_q == 7'd0) state_q <= S_DONE;
          else state_q <= S_RB_CLR;
        end
        S_RB_CLR, S_CO_CLR: begin
          d1_q <= '0;
          d2_q <= '0;
          state_q <= (state_q == S_RB_CLR) ? S_RB_ADDR : S_CO_ADDR;
        end
        S_RB_ADDR, S_RB_MAC, S_CO_ADDR, S_CO_DIV, S_CO_WAIT: begin
          if ((state_q == S_RB_ADDR || state_q == S_CO_ADDR) && win_ok) begin
            state_q <= (state_q == S_RB_ADDR) ? S_RB_MAC : S_CO_MUL;
          end else if (state_q == S_CO_DIV && !status_i.den_zero) begin
            state_q <= S_CO_WAIT;
          end else if (state_q == S_CO_WAIT && !status_i.div_done) begin
            state_q <= S_CO_WAIT;
          end else if (win_last) begin
            state_q <= (state_q == S_RB_ADDR || state_q == S_RB_MAC) ? S_RB_STORE : S_EST_ADDR;
          end else begin
            // Advance the window, row-major.
            if (d2_q == {hc_q, 1'b0}) begin
              d2_q <= '0;
              d1_q <= d1_q + 4'd1;
            end else begin
              d2_q <= d2_q + 4'd1;
            end
            state_q <= (state_q == S_RB_ADDR || state_q == S_RB_MAC) ? S_RB_ADDR : S_CO_ADDR;
          end
        end
        S_CO_MUL:   state_q <= S_CO_DIV;
        S_EST_ADDR: state_q <= S_EST_MUL;
        S_EST_MUL:  state_q <= S_NEXT_STORE;
        S_CP_ADDR:  state_q <= S_CP_STORE;
        S_RB_STORE, S_NEXT_STORE, S_CP_STORE: begin
          if (pix_last) begin
            r_q <= '0;
            c_q <= '0;
            unique case (state_q)
              S_RB_STORE:   state_q <= S_CO_CLR;
              S_NEXT_STORE: state_q <= S_CP_ADDR;
              default:      state_q <= S_ITER_END;
            endcase
          end else begin
            if (c_q == nc_q - 7'd1) begin
              c_q <= '0;
              r_q <= r_q + 7'd1;
            end else begin
              c_q <= c_q + 7'd1;
            end
            unique case (state_q)
              S_RB_STORE:   state_q <= S_RB_CLR;
              S_NEXT_STORE: state_q <= S_CO_CLR;
              default:      state_q <= S_CP_ADDR;
            endcase
          end
        end
        S_ITER_END: begin
          it_q <= it_q + 8'd1;
          if (it_q + 8'd1 == cfg_i.iterations) state_q <= S_DONE;
          else state_q <= S_RB_CLR;
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/richardson_lucy_deconvolve_unit.sv =====
// Top level of the Richardson-Lucy deconvolution unit: configuration registers,
// controller and datapath. Depends on rld_pkg, rld_ctrl and rld_datapath.
//
// Use:
//   Input beats (in_valid_i/in_ready_o, in_data_i) carry one of four operations:
//   load a kernel coefficient, load an observed/estimate pixel pair, run the
//   configured number of iterations, or read one estimate pixel. Loads give no
//   output beat; a run gives one beat with run_done set and pixel_value zero; a
//   read gives one beat with the stored estimate pixel (zero outside the store).
//   Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at once
//   and must be made only while the unit is idle; the unit does not enforce this.
// Timing:
//   Loads are taken one per cycle while no output beat is held back. A read passes
//   through S_READ before its beat is registered at the output. A run takes,
//   per iteration, a reblur pass, a correction pass (the 24-step bit-serial
//   divider runs for each in-image window position with nonzero reblur and is
//   skipped for a zero reblur or outside the image), a copy back of each pixel
//   and a step to close the iteration.
//   One item is in work at a time; the next is taken once it has finished.
// Reset and stall:
//   Reset restores the configuration defaults and idles the controller; image and
//   kernel stores hold whatever they held and must be loaded before a run.
//   The output register holds its beat while out_ready_i is low; a new item is
//   taken only once that beat is leaving or gone.
`default_nettype none

module richardson_lucy_deconvolve_unit #(
  parameter int MAX_ROWS   = rld_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = rld_pkg::MAX_COLS_DEF,
  parameter int MAX_KERNEL = rld_pkg::MAX_KERNEL_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rld_pkg::rld_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rld_pkg::rld_out_t      out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [7:0]        cfg_data_i
);
  import rld_pkg::*;

  localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
  localparam int KAW = (MAX_KERNEL * MAX_KERNEL > 1) ? $clog2(MAX_KERNEL * MAX_KERNEL) : 1;

  rld_cfg_t    cfg_q;
  rld_cmd_t    cmd;
  rld_status_t status;
  logic [AW-1:0]  pix_addr;
  logic [KAW-1:0] kern_addr;

  // Configuration registers: truncate each write to the register's width,
  // drop writes to unused indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_rows  <= IMAGE_ROWS_RST;
      cfg_q.image_cols  <= IMAGE_COLS_RST;
      cfg_q.kernel_rows <= KERNEL_ROWS_RST;
      cfg_q.kernel_cols <= KERNEL_COLS_RST;
      cfg_q.iterations  <= ITERATIONS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_ROWS:  cfg_q.image_rows  <= cfg_data_i[6:0];
        CFG_IMAGE_COLS:  cfg_q.image_cols  <= cfg_data_i[6:0];
        CFG_KERNEL_ROWS: cfg_q.kernel_rows <= cfg_data_i[2:0];
        CFG_KERNEL_COLS: cfg_q.kernel_cols <= cfg_data_i[2:0];
        CFG_ITERATIONS:  cfg_q.iterations  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rld_ctrl #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_KERNEL (MAX_KERNEL),
    .AW         (AW),
    .KAW        (KAW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_i       (cfg_q),
    .status_i    (status),
    .cmd_o       (cmd),
    .pix_addr_o  (pix_addr),
    .kern_addr_o (kern_addr)
  );

  rld_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_KERNEL (MAX_KERNEL),
    .AW         (AW),
    .KAW        (KAW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .pix_addr_i  (pix_addr),
    .kern_addr_i (kern_addr),
    .in_data_i   (in_data_i),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/rld_checker.sv =====
// Port-level checks on the deconvolution unit, bound to its top level.
// Depends on rld_pkg.
`default_nettype none

module rld_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire rld_pkg::rld_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire rld_pkg::rld_out_t out_data_o
);
  import rld_pkg::*;

  // A held output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // Never take an item while a result would be left stranded.
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("input taken while output slot blocked");

  // A read is answered with a pixel beat.
  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.func == FUNC_READ
      |-> ##2 out_valid_o && !out_data_o.run_done)
    else $error("read result missing");

  // A run keeps the input closed on the next cycle.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.func == FUNC_RUN |=> !in_ready_o)
    else $error("input open right after a run was taken");

endmodule

bind richardson_lucy_deconvolve_unit rld_checker u_rld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
